### rtl/core/lpcp_pkg.sv
// Shared types and constants for the lidar point to camera projector.
`default_nettype none
package lpcp_pkg;

	localparam int CW      = 32;
	localparam int COORD_W = 20;
	localparam int IDX_W   = 17;
	localparam int PIX_W   = 12;
	localparam int CODE_W  = 8;
	localparam int DIM_W   = 13;
	localparam int NUM_REG = 8;

	// Quotient bits of the pixel divider and working widths of the numerator.
	localparam int QBITS = PIX_W;
	localparam int NUM_W = 56;
	localparam int REM_W = NUM_W + QBITS - 1;

	localparam logic signed [COORD_W-1:0] X_LOW_RAW  = 20'sd1280;
	localparam logic signed [COORD_W-1:0] X_HIGH_RAW = 20'sd20480;
	localparam logic [DIM_W-1:0]          BOUND_MAX  = 13'd4096;

	typedef struct packed {
		logic [5:0][63:0]  coef;
		logic [DIM_W-1:0]  width_bound;
		logic [DIM_W-1:0]  height_bound;
	} cfg_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] num;
		logic [NUM_W-1:0]        den;
	} frac_t;

endpackage
`default_nettype wire

### rtl/core/lpcp_regs.sv
// APB configuration registers: projection coefficients and image bounds.
`default_nettype none
module lpcp_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	output lpcp_pkg::cfg_t     cfg
);

	typedef enum logic [2:0] {
		REG_U_XY, REG_U_ZT, REG_V_XY, REG_V_ZT,
		REG_W_XY, REG_W_ZT, REG_WIDTH, REG_HEIGHT
	} reg_idx_t;

	localparam logic [lpcp_pkg::DIM_W-1:0] WIDTH_RST  = 13'd1242;
	localparam logic [lpcp_pkg::DIM_W-1:0] HEIGHT_RST = 13'd375;

	logic [5:0][63:0]              coef_q;
	logic [lpcp_pkg::DIM_W-1:0]    width_q;
	logic [lpcp_pkg::DIM_W-1:0]    height_q;
	logic                          wr_en;
	reg_idx_t                      idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_U_XY, REG_U_ZT, REG_V_XY,
				REG_V_ZT, REG_W_XY, REG_W_ZT: coef_q[idx] <= pwdata;
				REG_WIDTH:  width_q  <= pwdata[lpcp_pkg::DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[lpcp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {{(64-lpcp_pkg::DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(64-lpcp_pkg::DIM_W){1'b0}}, height_q};
			default:    prdata = coef_q[idx];
		endcase
	end

	always_comb begin
		cfg.coef         = coef_q;
		cfg.width_bound  = (width_q > lpcp_pkg::BOUND_MAX) ? lpcp_pkg::BOUND_MAX : width_q;
		cfg.height_bound = (height_q > lpcp_pkg::BOUND_MAX) ? lpcp_pkg::BOUND_MAX : height_q;
	end

endmodule
`default_nettype wire

### rtl/core/lpcp_code.sv
// Clamped 8-bit color codes of x, y and z.
`default_nettype none
module lpcp_code (
	input  logic signed [lpcp_pkg::COORD_W-1:0] px,
	input  logic signed [lpcp_pkg::COORD_W-1:0] py,
	input  logic signed [lpcp_pkg::COORD_W-1:0] pz,
	output logic [lpcp_pkg::CODE_W-1:0]         x_code,
	output logic [lpcp_pkg::CODE_W-1:0]         y_code,
	output logic [lpcp_pkg::CODE_W-1:0]         z_code
);

	localparam int TW = lpcp_pkg::COORD_W + 1;
	localparam int SN = TW + 8;
	localparam logic [16:0] RECIP5 = 17'd52429;
	localparam logic [18:0] SAT5   = 19'd1280;
	localparam logic [18:0] SAT1   = 19'd256;

	// floor(m / 5) by reciprocal, exact below 1280; saturate above
	function automatic logic [7:0] div5_clamp(input logic [18:0] m);
		logic [27:0] p;
		begin
			p = 28'(m[10:0]) * 28'(RECIP5);
			div5_clamp = (m >= SAT5) ? 8'hFF : p[25:18];
		end
	endfunction

	logic signed [TW-1:0] xt, yt, zt;
	logic signed [SN-1:0] xn, yn, zn;

	always_comb begin
		xt = TW'(px) - 21'sd1536;
		yt = TW'(py) + 21'sd2560;
		zt = TW'(pz) + 21'sd512;
		xn = (SN'(xt) <<< 8) - SN'(xt);
		yn = (SN'(yt) <<< 8) - SN'(yt);
		zn = (SN'(zt) <<< 8) - SN'(zt);

		if (xn <= 0) x_code = '0;
		else         x_code = div5_clamp({1'b0, xn[SN-1:11]});

		if (yn <= 0) y_code = '0;
		else         y_code = div5_clamp(yn[SN-1:10]);

		if (zn <= 0)                  z_code = '0;
		else if (zn[SN-1:10] >= SAT1) z_code = 8'hFF;
		else                          z_code = zn[17:10];
	end

endmodule
`default_nettype wire

### rtl/core/lpcp_mac.sv
// Three-stage matrix product: forms rounding numerators and denominator for u and v.
`default_nettype none
module lpcp_mac (
	input  logic                                clk,
	input  logic signed [lpcp_pkg::COORD_W-1:0] px,
	input  logic signed [lpcp_pkg::COORD_W-1:0] py,
	input  logic signed [lpcp_pkg::COORD_W-1:0] pz,
	input  lpcp_pkg::cfg_t                      cfg,
	output lpcp_pkg::frac_t                     u_frac,
	output lpcp_pkg::frac_t                     v_frac,
	output logic                                w_pos
);

	localparam int CW     = lpcp_pkg::CW;
	localparam int PROD_W = CW + lpcp_pkg::COORD_W;
	localparam int NUM_W  = lpcp_pkg::NUM_W;
	localparam int SUM_W  = NUM_W - 2;

	logic signed [CW-1:0]     cx [3];
	logic signed [CW-1:0]     cy [3];
	logic signed [CW-1:0]     cz [3];
	logic signed [CW-1:0]     ct [3];

	logic signed [PROD_W-1:0] px_s1 [3];
	logic signed [PROD_W-1:0] py_s1 [3];
	logic signed [PROD_W-1:0] pz_s1 [3];
	logic signed [CW-1:0]     trans_s1 [3];
	logic signed [SUM_W-1:0]  sum_s2 [3];

	logic signed [NUM_W-1:0]  num_u_s3, num_v_s3;
	logic [NUM_W-1:0]         den_s3;
	logic                     wpos_s3;
	logic signed [NUM_W-1:0]  ue, ve, we;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			cx[r] = signed'(cfg.coef[2*r][31:0]);
			cy[r] = signed'(cfg.coef[2*r][63:32]);
			cz[r] = signed'(cfg.coef[2*r+1][31:0]);
			ct[r] = signed'(cfg.coef[2*r+1][63:32]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			px_s1[r]    <= cx[r] * px;
			py_s1[r]    <= cy[r] * py;
			pz_s1[r]    <= cz[r] * pz;
			trans_s1[r] <= ct[r];
		end
	end

	// translation is in metres; coordinates stay in 1/256 m
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s2[r] <= SUM_W'(px_s1[r]) + SUM_W'(py_s1[r]) + SUM_W'(pz_s1[r])
				+ SUM_W'($signed({trans_s1[r], 8'b0}));
		end
	end

	// round(u/w) = floor((2u + w) / 2w), with a tie fix-up after the divide
	always_comb begin
		ue = NUM_W'(sum_s2[0]);
		ve = NUM_W'(sum_s2[1]);
		we = NUM_W'(sum_s2[2]);
	end

	always_ff @(posedge clk) begin
		num_u_s3 <= (ue <<< 1) + we;
		num_v_s3 <= (ve <<< 1) + we;
		den_s3   <= unsigned'(we <<< 1);
		wpos_s3  <= (sum_s2[2] > 0);
	end

	always_comb begin
		u_frac.num = num_u_s3;
		u_frac.den = den_s3;
		v_frac.num = num_v_s3;
		v_frac.den = den_s3;
		w_pos      = wpos_s3;
	end

endmodule
`default_nettype wire

### rtl/core/lpcp_div.sv
// Pipelined restoring divider: one quotient bit per stage after a range check.
`default_nettype none
module lpcp_div (
	input  logic                       clk,
	input  logic                       en,
	input  lpcp_pkg::frac_t            frac,
	output logic [lpcp_pkg::QBITS-1:0] quot,
	output logic                       exact,
	output logic                       ok
);

	localparam int QBITS = lpcp_pkg::QBITS;
	localparam int NUM_W = lpcp_pkg::NUM_W;
	localparam int REM_W = lpcp_pkg::REM_W;

	logic [REM_W-1:0] rem_s [0:QBITS];
	logic [NUM_W-1:0] den_s [0:QBITS];
	logic [QBITS-1:0] q_s   [0:QBITS];
	logic             ok_s  [0:QBITS];

	logic [REM_W-1:0] sub [1:QBITS];
	logic             ge  [1:QBITS];
	logic [REM_W-1:0] num_mag;
	logic             big;

	// quotient must fit the pixel range; a negative numerator is out of view
	always_comb begin
		num_mag = REM_W'(frac.num[NUM_W-2:0]);
		big     = num_mag >= (REM_W'(frac.den) << QBITS);
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num_mag;
		den_s[0] <= frac.den;
		q_s[0]   <= '0;
		ok_s[0]  <= en && !frac.num[NUM_W-1] && !big;
	end

	always_comb begin
		for (int k = 1; k <= QBITS; k++) begin
			sub[k] = REM_W'(den_s[k-1]) << (QBITS - k);
			ge[k]  = rem_s[k-1] >= sub[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= QBITS; k++) begin
			rem_s[k] <= ge[k] ? (rem_s[k-1] - sub[k]) : rem_s[k-1];
			den_s[k] <= den_s[k-1];
			q_s[k]   <= {q_s[k-1][QBITS-2:0], ge[k]};
			ok_s[k]  <= ok_s[k-1];
		end
	end

	assign quot  = q_s[QBITS];
	assign exact = (rem_s[QBITS] == '0);
	assign ok    = ok_s[QBITS];

endmodule
`default_nettype wire

### rtl/core/lidar_point_camera_projector_top.sv
// Top level: lidar point to camera pixel projector.
// A result strobes on done once its start transfer has passed the datapath and the output register.
// Throughput: one point per cycle; busy is never raised, set by a fully pipelined
// datapath of 3 multiply/sum stages, a range stage and 12 divider bit stages.
// Reset (arst_n low) clears the valid line and restores the default registers.
// done cannot be held off; each result is present for exactly one cycle.
`default_nettype none
module lidar_point_camera_projector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [lpcp_pkg::COORD_W-1:0] point_x,
	input  logic signed [lpcp_pkg::COORD_W-1:0] point_y,
	input  logic signed [lpcp_pkg::COORD_W-1:0] point_z,
	input  logic [lpcp_pkg::IDX_W-1:0]          point_index,
	output logic                                done,
	output logic                                in_view,
	output logic [lpcp_pkg::PIX_W-1:0]          pixel_col,
	output logic [lpcp_pkg::PIX_W-1:0]          pixel_row,
	output logic [lpcp_pkg::IDX_W-1:0]          index_out,
	output logic [lpcp_pkg::CODE_W-1:0]         x_code,
	output logic [lpcp_pkg::CODE_W-1:0]         y_code,
	output logic [lpcp_pkg::CODE_W-1:0]         z_code,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [5:0]                          paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);

	localparam int SIDE_N = 3 + lpcp_pkg::QBITS + 1;
	localparam int PIX_W  = lpcp_pkg::PIX_W;

	typedef struct packed {
		logic [lpcp_pkg::IDX_W-1:0]  idx;
		logic                        win;
		logic [lpcp_pkg::CODE_W-1:0] xc;
		logic [lpcp_pkg::CODE_W-1:0] yc;
		logic [lpcp_pkg::CODE_W-1:0] zc;
	} side_t;

	lpcp_pkg::cfg_t  cfg;
	lpcp_pkg::frac_t u_frac, v_frac;
	logic            w_pos;
	logic [PIX_W-1:0] q_u, q_v, col, row;
	logic            exact_u, exact_v, ok_u, ok_v, hit;
	logic [lpcp_pkg::CODE_W-1:0] xc, yc, zc;

	logic  vld_s  [1:SIDE_N];
	side_t side_s [1:SIDE_N];

	logic                        done_s17, view_s17;
	logic [PIX_W-1:0]            col_s17, row_s17;
	logic [lpcp_pkg::IDX_W-1:0]  idx_s17;
	logic [lpcp_pkg::CODE_W-1:0] xc_s17, yc_s17, zc_s17;

	assign busy = 1'b0;

	lpcp_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	lpcp_code u_code (
		.px(point_x), .py(point_y), .pz(point_z),
		.x_code(xc), .y_code(yc), .z_code(zc)
	);

	lpcp_mac u_mac (
		.clk, .px(point_x), .py(point_y), .pz(point_z), .cfg,
		.u_frac, .v_frac, .w_pos
	);

	lpcp_div u_div_col (
		.clk, .en(w_pos), .frac(u_frac), .quot(q_u), .exact(exact_u), .ok(ok_u)
	);

	lpcp_div u_div_row (
		.clk, .en(w_pos), .frac(v_frac), .quot(q_v), .exact(exact_v), .ok(ok_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SIDE_N; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int k = 2; k <= SIDE_N; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[1].idx <= point_index;
		side_s[1].win <= (point_x > lpcp_pkg::X_LOW_RAW) && (point_x < lpcp_pkg::X_HIGH_RAW);
		side_s[1].xc  <= xc;
		side_s[1].yc  <= yc;
		side_s[1].zc  <= zc;
		for (int k = 2; k <= SIDE_N; k++) side_s[k] <= side_s[k-1];
	end

	// exact half rounded up to an odd value: step back to the even neighbor
	always_comb begin
		col = q_u - PIX_W'(exact_u && q_u[0]);
		row = q_v - PIX_W'(exact_v && q_v[0]);
		hit = side_s[SIDE_N].win && ok_u && ok_v
			&& ({1'b0, col} < cfg.width_bound) && ({1'b0, row} < cfg.height_bound);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s17 <= 1'b0;
			view_s17 <= 1'b0;
		end else begin
			done_s17 <= vld_s[SIDE_N];
			view_s17 <= vld_s[SIDE_N] && hit;
		end
	end

	always_ff @(posedge clk) begin
		col_s17 <= hit ? col : '0;
		row_s17 <= hit ? row : '0;
		idx_s17 <= side_s[SIDE_N].idx;
		xc_s17  <= hit ? side_s[SIDE_N].xc : '0;
		yc_s17  <= hit ? side_s[SIDE_N].yc : '0;
		zc_s17  <= hit ? side_s[SIDE_N].zc : '0;
	end

	assign done      = done_s17;
	assign in_view   = view_s17;
	assign pixel_col = col_s17;
	assign pixel_row = row_s17;
	assign index_out = idx_s17;
	assign x_code    = xc_s17;
	assign y_code    = yc_s17;
	assign z_code    = zc_s17;

`ifndef ASSERT_OFF
	a_view_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !in_view)
		else $error("in_view high without done");

	a_col_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && in_view) |-> ({1'b0, pixel_col} < cfg.width_bound
			&& {1'b0, pixel_row} < cfg.height_bound))
		else $error("in-view pixel outside image bounds");

	a_out_of_view_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_view) |-> (pixel_col == '0 && pixel_row == '0
			&& x_code == '0 && y_code == '0 && z_code == '0))
		else $error("out-of-view result carries nonzero fields");
`endif

endmodule
`default_nettype wire
